/* sv/assert_macros.svh */
// Assertion helpers; clk and rst_n must be in scope at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk, off during reset.
`define REW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* sv/rew_pkg.sv */
`default_nettype none

package rew_pkg;

    typedef enum logic [2:0] {
        OP_WR_EDGE   = 3'd0,
        OP_WR_VERTEX = 3'd1,
        OP_START     = 3'd2,
        OP_TICK      = 3'd3,
        OP_RD_VISIT  = 3'd4
    } op_t;

    typedef enum logic [0:0] {
        REG_EDGE_COUNT = 1'b0,
        REG_WALK_SPEED = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START_RD,
        S_VA,
        S_VB,
        S_VLOAD,
        S_DINIT,
        S_DIV,
        S_ADV,
        S_SCAN1,
        S_LCG_MUL,
        S_LCG_ADD,
        S_MOD,
        S_SCAN2,
        S_MUL,
        S_ACC,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [7:0]         index;
        logic [7:0]         vertex_a;
        logic [7:0]         vertex_b;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic signed [15:0] screen_depth;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] walker_depth;
        logic [9:0]         order_bucket;
        logic               sprite_visible;
        logic [5:0]         sprite_u;
        logic               visited_flag;
        logic [7:0]         walk_edge;
    } res_t;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } vertex_t;

    localparam logic [31:0] LCG_MUL   = 32'd1664525;
    localparam logic [31:0] LCG_ADD   = 32'd1013904223;
    localparam logic [31:0] SEED_BASE = 32'h12345678;
    localparam logic [11:0] WALK_SPEED_RESET = 12'd1365;
    localparam int          BUCKET_BIAS = 8;

endpackage

`default_nettype wire

/* sv/random_edge_walker.sv */
`default_nettype none
`include "assert_macros.svh"

// Random edge walker: a sprite wandering over the edges of a wire model.
// Command channel: cmd is taken when start is high and busy is low. Every
// item yields exactly one result on result, marked by done for one cycle;
// the receiver cannot stall, so done is never held.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 edge_count,
// 1 walk_speed) and cfg_data; cfg_ready is always high, write only when idle.
// Table writes, visited reads, and start or tick with no active edge give
// done in the next cycle; other starts read edge 0 via S_START_RD. A tick
// where the walker stays on its edge runs a 12-step restoring divider for
// the progress step and 3 interpolation multiplies; on arrival it adds a
// pass over the active edges (one entry a cycle), then, unless at a dead
// end, an LCG step, a 24-step modulo unit, a second pass and a vertex fetch.
// One item is in flight at a time. Reset clears the walker state and visited
// marks; edge and vertex memories hold nothing valid until written.
module random_edge_walker #(
    parameter int EDGE_SLOTS   = 256,
    parameter int VERTEX_SLOTS = 256,
    parameter int BUCKET_COUNT = 1024,
    parameter int DEPTH_SHIFT  = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire rew_pkg::cmd_t cmd,
    output logic              done,
    output rew_pkg::res_t     result,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [11:0]  cfg_data
);
    import rew_pkg::*;

    localparam int EW = $clog2(EDGE_SLOTS);
    localparam int NW = EW + 1;
    localparam int VW = $clog2(VERTEX_SLOTS);

    logic [15:0] edge_mem [EDGE_SLOTS];
    logic [47:0] vert_mem [VERTEX_SLOTS];

    state_t state_reg, state_next;

    logic [8:0]  edge_count_reg, edge_count_next;
    logic [11:0] walk_speed_reg, walk_speed_next;
    logic [EDGE_SLOTS-1:0] visited_reg, visited_next;
    logic [31:0] rng_reg, rng_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic [7:0]  from_reg, from_next;
    logic [7:0]  to_reg, to_next;
    logic [12:0] prog_reg, prog_next;
    logic [3:0]  frame_reg, frame_next;

    vertex_t a_reg, a_next, b_reg, b_next;
    logic        second_reg, second_next;
    logic [16:0] len_reg, len_next;
    logic [16:0] rem_reg, rem_next;
    logic [11:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [23:0] dvd_reg, dvd_next;
    logic [NW-1:0] scan_reg, scan_next;
    logic        pv_reg, pv_next;
    logic [EW-1:0] pe_reg, pe_next;
    logic [NW-1:0] count_reg, count_next;
    logic [NW-1:0] pick_reg, pick_next;
    logic [NW-1:0] mrem_reg, mrem_next;
    logic        found_reg, found_next;
    logic [31:0] lprod_reg, lprod_next;
    logic [1:0]  k_reg, k_next;
    logic signed [30:0] mprod_reg, mprod_next;
    logic signed [15:0] px_reg, px_next, py_reg, py_next, pd_reg, pd_next;
    res_t        res_reg, res_next;
    logic        done_reg, done_next;

    // memory ports
    logic          ewe;
    logic [EW-1:0] ewaddr, eraddr;
    logic [15:0]   ewdata, eq;
    logic          vwe;
    logic [VW-1:0] vwaddr, vraddr;
    logic [47:0]   vwdata, vq;
    logic          vrange, vrange_reg;
    logic [7:0]    vsel;
    vertex_t       vdata;

    logic          accept;
    logic [NW-1:0] n_act;
    logic [31:0]   idx32;
    logic [7:0]    ea, eb;
    logic          ematch;
    logic          scan_done;
    logic signed [16:0] dx, dy, ddiff;
    logic [16:0]   adx, ady, len_w;
    logic [17:0]   dsh;
    logic [NW:0]   msh;
    logic [31:0]   rng_new;
    logic signed [15:0] a_k;
    logic signed [31:0] bk;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = res_reg;
    assign idx32     = 32'(cmd.index);
    assign n_act     = (32'(edge_count_reg) > EDGE_SLOTS) ? NW'(EDGE_SLOTS)
                                                          : NW'(edge_count_reg);

    // edge memory
    always_ff @(posedge clk)
    begin
        if (ewe)
        begin
            edge_mem[ewaddr] <= ewdata;
        end
        eq <= edge_mem[eraddr];
    end

    // vertex memory; out-of-range vertex numbers read as zero
    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            vert_mem[vwaddr] <= vwdata;
        end
        vq <= vert_mem[vraddr];
    end

    assign ewe    = accept && (cmd.op == OP_WR_EDGE) && (idx32 < EDGE_SLOTS);
    assign ewaddr = idx32[EW-1:0];
    assign ewdata = {cmd.vertex_b, cmd.vertex_a};
    assign eraddr = (state_reg == S_IDLE) ? '0 : scan_reg[EW-1:0];

    assign vwe    = accept && (cmd.op == OP_WR_VERTEX) && (idx32 < VERTEX_SLOTS);
    assign vwaddr = idx32[VW-1:0];
    assign vwdata = {cmd.screen_depth, cmd.screen_y, cmd.screen_x};
    assign vsel   = (state_reg == S_VB) ? to_reg : from_reg;
    assign vrange = (32'(vsel) < VERTEX_SLOTS);
    assign vraddr = VW'(32'(vsel));
    assign vdata  = vrange_reg ? vertex_t'(vq) : vertex_t'('0);

    // scan pipeline: entry pe_reg was read last cycle
    assign ea        = eq[7:0];
    assign eb        = eq[15:8];
    assign ematch    = pv_reg && (pe_reg != cur_reg) && ((ea == to_reg) || (eb == to_reg));
    assign scan_done = (scan_reg >= n_act) && !pv_reg;

    assign dx    = 17'(b_reg.x) - 17'(a_reg.x);
    assign dy    = 17'(b_reg.y) - 17'(a_reg.y);
    assign adx   = dx[16] ? 17'(-dx) : 17'(dx);
    assign ady   = dy[16] ? 17'(-dy) : 17'(dy);
    assign len_w = adx + ady;
    assign dsh   = {rem_reg, dvd_reg[23]};
    assign msh   = {mrem_reg, dvd_reg[23]};
    assign rng_new = lprod_reg + LCG_ADD;

    always_comb
    begin
        case (k_reg)
            2'd0:    begin ddiff = 17'(b_reg.x) - 17'(a_reg.x); a_k = a_reg.x; end
            2'd1:    begin ddiff = 17'(b_reg.y) - 17'(a_reg.y); a_k = a_reg.y; end
            default: begin ddiff = 17'(b_reg.z) - 17'(a_reg.z); a_k = a_reg.z; end
        endcase
    end

    assign bk = ((32'(pd_reg) * 32'sd3) >>> (2 + DEPTH_SHIFT)) - BUCKET_BIAS;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.op == OP_START && n_act != '0)
                        state_next = S_START_RD;
                    else if (cmd.op == OP_TICK && n_act != '0)
                        state_next = S_VA;
                end
            end
            S_START_RD: state_next = S_IDLE;
            S_VA:       state_next = S_VB;
            S_VB:       state_next = S_VLOAD;
            S_VLOAD:    state_next = second_reg ? S_MUL : S_DINIT;
            S_DINIT:    state_next = S_DIV;
            S_DIV:      state_next = (cnt_reg == '0) ? S_ADV : S_DIV;
            S_ADV:      state_next = prog_next[12] ? S_SCAN1 : S_MUL;
            S_SCAN1:
            begin
                if (scan_done)
                    state_next = (count_reg == '0) ? S_MUL : S_LCG_MUL;
            end
            S_LCG_MUL:  state_next = S_LCG_ADD;
            S_LCG_ADD:  state_next = S_MOD;
            S_MOD:      state_next = (cnt_reg == '0) ? S_SCAN2 : S_MOD;
            S_SCAN2:    state_next = scan_done ? S_VA : S_SCAN2;
            S_MUL:      state_next = S_ACC;
            S_ACC:      state_next = (k_reg == 2'd2) ? S_FINISH : S_MUL;
            S_FINISH:   state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        edge_count_next = edge_count_reg;
        walk_speed_next = walk_speed_reg;
        visited_next = visited_reg;
        rng_next   = rng_reg;
        cur_next   = cur_reg;
        from_next  = from_reg;
        to_next    = to_reg;
        prog_next  = prog_reg;
        frame_next = frame_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        second_next = second_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        scan_next  = scan_reg;
        pv_next    = 1'b0;
        pe_next    = pe_reg;
        count_next = count_reg;
        pick_next  = pick_reg;
        mrem_next  = mrem_reg;
        found_next = found_reg;
        lprod_next = lprod_reg;
        k_next     = k_reg;
        mprod_next = mprod_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pd_next    = pd_reg;
        res_next   = '0;
        done_next  = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == 2'(REG_EDGE_COUNT))
                edge_count_next = cfg_data[8:0];
            else if (cfg_index == 2'(REG_WALK_SPEED))
                walk_speed_next = cfg_data;
        end

        // scan issue: one edge entry per cycle
        if ((state_reg == S_SCAN1 || state_reg == S_SCAN2) && scan_reg < n_act)
        begin
            pv_next   = 1'b1;
            pe_next   = scan_reg[EW-1:0];
            scan_next = scan_reg + 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.op)
                        OP_START:
                        begin
                            visited_next = '0;
                            rng_next   = SEED_BASE ^ 32'(edge_count_reg);
                            cur_next   = '0;
                            prog_next  = '0;
                            frame_next = '0;
                            if (n_act == '0)
                                done_next = 1'b1;
                        end
                        OP_TICK:
                        begin
                            second_next = 1'b0;
                            if (n_act == '0)
                                done_next = 1'b1;
                        end
                        OP_RD_VISIT:
                        begin
                            done_next = 1'b1;
                            if (idx32 < EDGE_SLOTS)
                                res_next.visited_flag = visited_reg[idx32[EW-1:0]];
                        end
                        default: done_next = 1'b1;
                    endcase
                end
            end
            S_START_RD:
            begin
                from_next = eq[7:0];
                to_next   = eq[15:8];
                visited_next[0] = 1'b1;
                done_next = 1'b1;
            end
            S_VB:    a_next = vdata;
            S_VLOAD:
            begin
                b_next = vdata;
                k_next = '0;
            end
            S_DINIT:
            begin
                len_next = (len_w == '0) ? 17'd1 : len_w;
                rem_next = '0;
                q_next   = '0;
                cnt_next = 5'd11;
                dvd_next = {walk_speed_reg, 12'd0};
            end
            S_DIV:
            begin
                dvd_next = {dvd_reg[22:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (dsh >= {1'b0, len_reg})
                begin
                    rem_next = 17'(dsh - {1'b0, len_reg});
                    q_next   = {q_reg[10:0], 1'b1};
                end
                else
                begin
                    rem_next = dsh[16:0];
                    q_next   = {q_reg[10:0], 1'b0};
                end
            end
            S_ADV:
            begin
                prog_next  = prog_reg + 13'(q_reg);
                frame_next = frame_reg + 1'b1;
                scan_next  = '0;
                count_next = '0;
                k_next     = '0;
            end
            S_SCAN1:
            begin
                if (ematch)
                    count_next = count_reg + 1'b1;
                if (scan_done && count_reg == '0)
                begin
                    // dead end: turn around
                    from_next = to_reg;
                    to_next   = from_reg;
                    a_next    = b_reg;
                    b_next    = a_reg;
                    prog_next = '0;
                end
            end
            S_LCG_MUL: lprod_next = rng_reg * LCG_MUL;
            S_LCG_ADD:
            begin
                rng_next  = rng_new;
                dvd_next  = rng_new[31:8];
                mrem_next = '0;
                cnt_next  = 5'd23;
            end
            S_MOD:
            begin
                dvd_next = {dvd_reg[22:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (msh >= {1'b0, count_reg})
                    mrem_next = NW'(msh - {1'b0, count_reg});
                else
                    mrem_next = msh[NW-1:0];
                if (cnt_reg == '0)
                begin
                    pick_next  = (msh >= {1'b0, count_reg}) ? NW'(msh - {1'b0, count_reg})
                                                            : msh[NW-1:0];
                    scan_next  = '0;
                    found_next = 1'b0;
                end
            end
            S_SCAN2:
            begin
                if (ematch && !found_reg)
                begin
                    if (pick_reg == '0)
                    begin
                        found_next = 1'b1;
                        visited_next[pe_reg] = 1'b1;
                        cur_next  = pe_reg;
                        from_next = to_reg;
                        to_next   = (ea == to_reg) ? eb : ea;
                        prog_next = '0;
                    end
                    else
                    begin
                        pick_next = pick_reg - 1'b1;
                    end
                end
                if (scan_done)
                    second_next = 1'b1;
            end
            S_MUL: mprod_next = ddiff * $signed({1'b0, prog_reg});
            S_ACC:
            begin
                k_next = k_reg + 1'b1;
                case (k_reg)
                    2'd0:    px_next = a_k + 16'(mprod_reg >>> 12);
                    2'd1:    py_next = a_k + 16'(mprod_reg >>> 12);
                    default: pd_next = a_k + 16'(mprod_reg >>> 12);
                endcase
            end
            S_FINISH:
            begin
                done_next = 1'b1;
                res_next.pos_x = px_reg;
                res_next.pos_y = py_reg;
                res_next.walker_depth = pd_reg;
                if (pd_reg > 0)
                begin
                    res_next.sprite_visible = 1'b1;
                    if (bk <= 0)
                        res_next.order_bucket = 10'd1;
                    else if (bk >= BUCKET_COUNT)
                        res_next.order_bucket = 10'(BUCKET_COUNT - 1);
                    else
                        res_next.order_bucket = 10'(bk);
                    res_next.sprite_u = ((b_reg.x < a_reg.x) ? 6'd32 : 6'd0)
                                      + (frame_reg[3] ? 6'd16 : 6'd0);
                end
            end
            default: ;
        endcase

        res_next.walk_edge = 8'(cur_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_count_reg <= '0;
            walk_speed_reg <= WALK_SPEED_RESET;
            visited_reg    <= '0;
            rng_reg        <= '0;
            cur_reg        <= '0;
            from_reg       <= '0;
            to_reg         <= '0;
            prog_reg       <= '0;
            frame_reg      <= '0;
            second_reg     <= 1'b0;
            pv_reg         <= 1'b0;
            found_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            walk_speed_reg <= walk_speed_next;
            visited_reg    <= visited_next;
            rng_reg        <= rng_next;
            cur_reg        <= cur_next;
            from_reg       <= from_next;
            to_reg         <= to_next;
            prog_reg       <= prog_next;
            frame_reg      <= frame_next;
            second_reg     <= second_next;
            pv_reg         <= pv_next;
            found_reg      <= found_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vrange_reg <= vrange;
        a_reg      <= a_next;
        b_reg      <= b_next;
        len_reg    <= len_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
        dvd_reg    <= dvd_next;
        scan_reg   <= scan_next;
        pe_reg     <= pe_next;
        count_reg  <= count_next;
        pick_reg   <= pick_next;
        mrem_reg   <= mrem_next;
        lprod_reg  <= lprod_next;
        k_reg      <= k_next;
        mprod_reg  <= mprod_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pd_reg     <= pd_next;
        res_reg    <= res_next;
    end

    `REW_ASSERT(a_done_idle, done |-> !busy, "result strobe while busy")
    `REW_ASSERT(a_accept_moves, (start && !busy) |=> (busy || done), "item dropped")
    `REW_ASSERT(a_div_nonzero, (state_reg == S_DIV) |-> (len_reg != '0), "divide by zero")
    `REW_ASSERT(a_mod_nonzero, (state_reg == S_MOD) |-> (count_reg != '0), "modulo by zero")

endmodule

`default_nettype wire
